>>> rtl/door_open_monitor_led_status_unit_macros.svh
// Assertion macros for the door open monitor LED status unit.
// Depends on clk_i and rst_ni being visible at the point of use.
`ifndef DOOR_OPEN_MONITOR_LED_STATUS_UNIT_MACROS_SVH
`define DOOR_OPEN_MONITOR_LED_STATUS_UNIT_MACROS_SVH

// Same-cycle check, sampled on the rising clock edge, off during reset.
`define DOMLS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check in the cycle after the trigger.
`define DOMLS_ASSERT_NEXT(label, trig, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (prop)) \
    else $error(msg);

`endif

>>> rtl/domls_pkg.sv
// Shared types and constants for the door open monitor LED status unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package domls_pkg;

  localparam int unsigned DOOR_SLOTS = 8;
  localparam int unsigned TICK_W     = 16;
  localparam int unsigned CFG_ADDR_W = 8;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] CFG_TEST_ENABLE  = 8'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SIX_CHAMBERS = 8'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_OPEN_LIMIT   = 8'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_BLINK_RELOAD = 8'd3;

  localparam logic [TICK_W-1:0] OPEN_LIMIT_RST   = 16'd300;
  localparam logic [TICK_W-1:0] BLINK_RELOAD_RST = 16'd5;
  localparam logic [TICK_W-1:0] BLINK_COUNT_RST  = 16'd10;

  typedef struct packed {
    logic open;
    logic error;
    logic changed;
  } door_stat_t;

endpackage

`default_nettype wire

>>> rtl/domls_door.sv
// One door lane: open-time counter, error flag and seen-open edge tracker.
// Depends on domls_pkg.
`timescale 1ns / 1ps
`default_nettype none

module domls_door (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          tick_i,
  input  wire logic                          open_i,
  input  wire logic [domls_pkg::TICK_W-1:0]  limit_i,
  output domls_pkg::door_stat_t              stat_o
);
  import domls_pkg::*;

  logic [TICK_W-1:0] ticks_q, ticks_d;
  logic              err_q, err_d;
  logic              seen_q;

  always_comb begin
    ticks_d = ticks_q;
    err_d   = err_q;
    if (open_i) begin
      if (ticks_q == limit_i) begin
        err_d = 1'b1;
      end else begin
        ticks_d = ticks_q + 1'b1;
      end
    end else begin
      ticks_d = '0;
      err_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q <= '0;
      err_q   <= 1'b0;
      seen_q  <= 1'b0;
    end else if (tick_i) begin
      ticks_q <= ticks_d;
      err_q   <= err_d;
      seen_q  <= open_i;
    end
  end

  assign stat_o.open    = open_i;
  assign stat_o.error   = err_d;
  assign stat_o.changed = open_i ^ seen_q;

endmodule

`default_nettype wire

>>> rtl/domls_blink.sv
// Blink timer: down counter with reload and a toggling phase bit.
// Depends on domls_pkg.
`timescale 1ns / 1ps
`default_nettype none

module domls_blink (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          adv_i,
  input  wire logic [domls_pkg::TICK_W-1:0]  reload_i,
  output logic                               phase_o
);
  import domls_pkg::*;

  logic [TICK_W-1:0] cnt_q, cnt_d;
  logic              phase_q, phase_d;

  always_comb begin
    if (cnt_q == '0) begin
      cnt_d   = reload_i;
      phase_d = ~phase_q;
    end else begin
      cnt_d   = cnt_q - 1'b1;
      phase_d = phase_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= BLINK_COUNT_RST;
      phase_q <= 1'b0;
    end else if (adv_i) begin
      cnt_q   <= cnt_d;
      phase_q <= phase_d;
    end
  end

  assign phase_o = phase_d;

endmodule

`default_nettype wire

>>> rtl/door_open_monitor_led_status_unit.sv
// Door open monitor with LED status: one 0.1 s tick per beat, one result per tick.
// Each accepted tick is evaluated in a single pass across all door lanes and lands in
// the result register on the edge that accepts it, so a tick can be accepted every
// clock while in_stall_o is low. in_stall_o rises only while the result register is
// full and out_stall_i holds it. Reset needs no clearing pass. Depends on domls_pkg,
// domls_door, domls_blink and door_open_monitor_led_status_unit_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "door_open_monitor_led_status_unit_macros.svh"

module door_open_monitor_led_status_unit #(
  parameter int unsigned NUM_DOORS = 8
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [domls_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  wire logic [domls_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [7:0]                        door_pins_i,
  input  wire logic [7:0]                        working_bits_i,
  input  wire logic [15:0]                       test_colours_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [7:0]                             red_pins_o,
  output logic [7:0]                             green_pins_o,
  output logic [7:0]                             open_bits_o,
  output logic [7:0]                             error_bits_o,
  output logic                                   log_event_o,
  output logic [2:0]                             log_door_o,
  output logic                                   log_closed_o
);
  import domls_pkg::*;

  localparam int unsigned LIVE = (NUM_DOORS < DOOR_SLOTS) ? NUM_DOORS : DOOR_SLOTS;

  logic              test_q, six_q;
  logic [TICK_W-1:0] limit_q, reload_q;
  logic              cfg_acc, in_acc;
  logic              phase;
  door_stat_t        stat [DOOR_SLOTS];

  logic [7:0] red_d, green_d, open_d, err_d;
  logic       ev_d, closed_d;
  logic [2:0] door_d;

  logic       out_valid_q;
  logic [7:0] red_q, green_q, open_q, err_q;
  logic       ev_q, closed_q;
  logic [2:0] door_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i & cfg_ready_o;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_acc      = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      test_q   <= 1'b0;
      six_q    <= 1'b0;
      limit_q  <= OPEN_LIMIT_RST;
      reload_q <= BLINK_RELOAD_RST;
    end else if (cfg_acc) begin
      unique case (cfg_addr_i)
        CFG_TEST_ENABLE:  test_q   <= cfg_data_i[0];
        CFG_SIX_CHAMBERS: six_q    <= cfg_data_i[0];
        CFG_OPEN_LIMIT:   limit_q  <= cfg_data_i[TICK_W-1:0];
        CFG_BLINK_RELOAD: reload_q <= cfg_data_i[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < DOOR_SLOTS; i++) begin : g_door
    if (i < LIVE) begin : g_live
      localparam bit MASKABLE = (i >= 6);
      logic open;
      assign open = door_pins_i[7-i] & ~(six_q & MASKABLE);
      domls_door u_door (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .tick_i  (in_acc),
        .open_i  (open),
        .limit_i (limit_q),
        .stat_o  (stat[i])
      );
    end else begin : g_dead
      assign stat[i] = '0;
    end
  end

  domls_blink u_blink (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (in_acc & ~test_q),
    .reload_i (reload_q),
    .phase_o  (phase)
  );

  always_comb begin
    red_d    = '0;
    green_d  = '0;
    open_d   = '0;
    err_d    = '0;
    ev_d     = 1'b0;
    door_d   = '0;
    closed_d = 1'b0;
    for (int i = 0; i < DOOR_SLOTS; i++) begin
      open_d[i] = stat[i].open;
      err_d[i]  = stat[i].error;
      if (stat[i].changed) begin
        ev_d     = 1'b1;
        door_d   = 3'(i);
        closed_d = ~stat[i].open;
      end
    end
    for (int i = 0; i < LIVE; i++) begin
      if (test_q) begin
        red_d[7-i]   = test_colours_i[2*i];
        green_d[7-i] = test_colours_i[2*i+1];
      end else begin
        green_d[7-i] = stat[i].open ? phase : working_bits_i[i];
        red_d[7-i]   = ~green_d[7-i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= in_acc | (out_valid_q & out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      red_q    <= red_d;
      green_q  <= green_d;
      open_q   <= open_d;
      err_q    <= err_d;
      ev_q     <= ev_d;
      door_q   <= door_d;
      closed_q <= closed_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign red_pins_o   = red_q;
  assign green_pins_o = green_q;
  assign open_bits_o  = open_q;
  assign error_bits_o = err_q;
  assign log_event_o  = ev_q;
  assign log_door_o   = door_q;
  assign log_closed_o = closed_q;

  `DOMLS_ASSERT(a_err_needs_open, !out_valid_o || ((error_bits_o & ~open_bits_o) == 8'd0), "error bit set on a closed door")
  `DOMLS_ASSERT(a_quiet_log, !out_valid_o || log_event_o || (log_door_o == 3'd0 && !log_closed_o), "log fields set without a log event")
  `DOMLS_ASSERT_NEXT(a_result_follows, in_acc, out_valid_o, "accepted tick produced no result")

endmodule

`default_nettype wire

>>> tb/tb.sv
// Testbench for door_open_monitor_led_status_unit: directed and random ticks.
// Predicts each LED status beat in-line and checks it against the DUT output.
// Depends on domls_pkg and the RTL of the unit.
`timescale 1ns / 1ps

module tb;
  import domls_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned IDLE_PCT    = 22;
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE = 8'hFF;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] opened;
    logic [7:0] errs;
    logic       ev;
    logic [2:0] ev_door;
    logic       ev_closed;
  } led_status_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            door_pins = '0;
  logic [7:0]            working_bits = '0;
  logic [15:0]           test_colours = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [7:0]            red_pins;
  logic [7:0]            green_pins;
  logic [7:0]            open_bits;
  logic [7:0]            error_bits;
  logic                  log_event;
  logic [2:0]            log_door;
  logic                  log_closed;

  // predictor state and register copies
  logic        test_reg;
  logic        six_reg;
  logic [15:0] limit_reg;
  logic [15:0] reload_reg;
  logic [15:0] door_ticks [8];
  logic [7:0]  err_flags;
  logic [7:0]  seen_open;
  logic [15:0] blink_cnt;
  logic        blink_ph;

  led_status_t status_q [$];
  int unsigned n_fail = 0;
  int unsigned cycles = 0;
  logic        idling_on = 1'b1;
  logic [7:0]  pin_state = '0;

  door_open_monitor_led_status_unit u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_addr_i     (cfg_addr),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .door_pins_i    (door_pins),
    .working_bits_i (working_bits),
    .test_colours_i (test_colours),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .red_pins_o     (red_pins),
    .green_pins_o   (green_pins),
    .open_bits_o    (open_bits),
    .error_bits_o   (error_bits),
    .log_event_o    (log_event),
    .log_door_o     (log_door),
    .log_closed_o   (log_closed)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[door_open_monitor_led_status_unit] ERROR");
      $finish;
    end
  end

  function automatic led_status_t predict_tick(logic [7:0] pins, logic [7:0] working,
                                               logic [15:0] colours);
    led_status_t r;
    logic        is_open;
    logic        g;
    logic [1:0]  c;
    int          d;
    r = '0;
    for (d = 0; d < 8; d++) begin
      is_open = pins[7-d] && !(six_reg && d >= 6);
      if (is_open) begin
        r.opened[d] = 1'b1;
        if (door_ticks[d] == limit_reg) err_flags[d] = 1'b1;
        else door_ticks[d] = door_ticks[d] + 16'd1;
        if (!seen_open[d]) begin
          seen_open[d] = 1'b1;
          r.ev = 1'b1;
          r.ev_door = d[2:0];
          r.ev_closed = 1'b0;
        end
      end else begin
        door_ticks[d] = '0;
        err_flags[d] = 1'b0;
        if (seen_open[d]) begin
          seen_open[d] = 1'b0;
          r.ev = 1'b1;
          r.ev_door = d[2:0];
          r.ev_closed = 1'b1;
        end
      end
    end
    if (test_reg) begin
      for (d = 0; d < 8; d++) begin
        c = colours[2*d +: 2];
        r.red[7-d] = c[0];
        r.green[7-d] = c[1];
      end
    end else begin
      if (blink_cnt == 16'd0) begin
        blink_cnt = reload_reg;
        blink_ph = ~blink_ph;
      end else begin
        blink_cnt = blink_cnt - 16'd1;
      end
      for (d = 0; d < 8; d++) begin
        g = r.opened[d] ? blink_ph : working[d];
        r.green[7-d] = g;
        r.red[7-d] = !g;
      end
    end
    r.errs = err_flags;
    return r;
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      n_fail++;
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endtask

  always @(negedge clk) begin
    out_stall <= idling_on && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    led_status_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (status_q.size() == 0) begin
        n_fail++;
        $display("%0t: unexpected beat, expected none got red %0h green %0h",
                 $time, red_pins, green_pins);
      end else begin
        want = status_q.pop_front();
        check_field("red_pins", 16'(want.red), 16'(red_pins));
        check_field("green_pins", 16'(want.green), 16'(green_pins));
        check_field("open_bits", 16'(want.opened), 16'(open_bits));
        check_field("error_bits", 16'(want.errs), 16'(error_bits));
        check_field("log_event", 16'(want.ev), 16'(log_event));
        check_field("log_door", 16'(want.ev_door), 16'(log_door));
        check_field("log_closed", 16'(want.ev_closed), 16'(log_closed));
      end
    end
  end

  task automatic send_tick(logic [7:0] pins, logic [7:0] working, logic [15:0] colours);
    @(negedge clk);
    while (idling_on && ($urandom_range(99) < IDLE_PCT)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    door_pins <= pins;
    working_bits <= working;
    test_colours <= colours;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    status_q.push_back(predict_tick(pins, working, colours));
  endtask

  // hold off until every expected beat has come back
  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_TEST_ENABLE:  test_reg = data[0];
      CFG_SIX_CHAMBERS: six_reg = data[0];
      CFG_OPEN_LIMIT:   limit_reg = data;
      CFG_BLINK_RELOAD: reload_reg = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_mode(logic te, logic six, logic [15:0] lim, logic [15:0] reload);
    drain();
    write_reg(CFG_TEST_ENABLE, {15'($urandom_range(32767)), te});
    write_reg(CFG_SIX_CHAMBERS, {15'($urandom_range(32767)), six});
    write_reg(CFG_OPEN_LIMIT, lim);
    write_reg(CFG_BLINK_RELOAD, reload);
  endtask

  task automatic test_door_edges;
    send_tick(8'h00, 8'h00, 16'h0000);
    send_tick(8'hFF, 8'hFF, 16'hFFFF);
    send_tick(8'hFF, 8'h0F, 16'h0000);
    send_tick(8'h00, 8'hFF, 16'hFFFF);
    send_tick(8'h01, 8'hA5, 16'h5A5A);
    send_tick(8'h80, 8'h5A, 16'hA5A5);
    send_tick(8'h00, 8'h00, 16'h0000);
  endtask

  task automatic test_open_limit;
    drain();
    write_reg(CFG_OPEN_LIMIT, 16'd0);
    send_tick(8'h80, 8'h00, 16'h0000);
    send_tick(8'h80, 8'h00, 16'h0000);
    send_tick(8'h00, 8'h00, 16'h0000);
    drain();
    write_reg(CFG_OPEN_LIMIT, OPEN_LIMIT_RST);
    repeat (3) send_tick(8'h80, 8'h01, 16'h0000);
    // lower the limit below the running count: count runs on, no error
    drain();
    write_reg(CFG_OPEN_LIMIT, 16'd1);
    repeat (2) send_tick(8'h80, 8'h01, 16'h0000);
    drain();
    write_reg(CFG_OPEN_LIMIT, 16'd6);
    repeat (2) send_tick(8'h80, 8'h01, 16'h0000);
    // error stays set while the door stays open
    drain();
    write_reg(CFG_OPEN_LIMIT, 16'd2);
    send_tick(8'h80, 8'h01, 16'h0000);
    send_tick(8'h00, 8'h01, 16'h0000);
  endtask

  task automatic test_six_chambers;
    drain();
    write_reg(CFG_SIX_CHAMBERS, 16'hFFFF);
    send_tick(8'h03, 8'hC0, 16'h0000);
    send_tick(8'hC3, 8'hC0, 16'h0000);
    drain();
    write_reg(CFG_SIX_CHAMBERS, 16'h0000);
    send_tick(8'h03, 8'h3F, 16'h0000);
    send_tick(8'h00, 8'h3F, 16'h0000);
  endtask

  task automatic test_blink_and_test_mode;
    drain();
    write_reg(CFG_BLINK_RELOAD, 16'd0);
    send_tick(8'hF0, 8'h0F, 16'h0000);
    send_tick(8'hF0, 8'h0F, 16'h0000);
    drain();
    write_reg(CFG_TEST_ENABLE, 16'hFFFF);
    write_reg(CFG_SPARE, 16'hFFFF);
    send_tick(8'h55, 8'h00, 16'hE4E4);
    send_tick(8'hAA, 8'hFF, 16'h1B1B);
    drain();
    write_reg(CFG_TEST_ENABLE, 16'hFFFE);
    send_tick(8'h00, 8'h33, 16'hFFFF);
  endtask

  task automatic run_random_phase(int unsigned n_items);
    logic [7:0] pins;
    int         b;
    repeat (n_items) begin
      pins = pin_state;
      if ($urandom_range(99) < 15) begin
        pins = 8'($urandom_range(255));
      end else begin
        for (b = 0; b < 8; b++) begin
          if ($urandom_range(15) == 0) pins[b] = ~pins[b];
        end
      end
      pin_state = pins;
      if ($urandom_range(99) < 2) drain();
      send_tick(pins, 8'($urandom_range(255)), 16'($urandom_range(65535)));
    end
  endtask

  task automatic test_random;
    idling_on = 1'b0;
    set_mode(1'b0, 1'b0, 16'($urandom_range(40, 2)), 16'd0);
    run_random_phase(250);
    idling_on = 1'b1;
    set_mode(1'b1, 1'b1, 16'd0, 16'hFFFF);
    run_random_phase(250);
    set_mode(1'b0, 1'b1, 16'hFFFF, 16'hFFFF);
    run_random_phase(250);
    set_mode(1'b0, 1'b0, 16'd1, 16'($urandom_range(8, 1)));
    run_random_phase(250);
    set_mode(1'b1, 1'b0, 16'($urandom_range(40, 2)), 16'd0);
    run_random_phase(250);
    set_mode(1'b0, 1'b0, OPEN_LIMIT_RST, BLINK_RELOAD_RST);
    run_random_phase(250);
  endtask

  initial begin
    test_reg = 1'b0;
    six_reg = 1'b0;
    limit_reg = OPEN_LIMIT_RST;
    reload_reg = BLINK_RELOAD_RST;
    for (int d = 0; d < 8; d++) door_ticks[d] = '0;
    err_flags = '0;
    seen_open = '0;
    blink_cnt = BLINK_COUNT_RST;
    blink_ph = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_door_edges();
    test_open_limit();
    test_six_chambers();
    test_blink_and_test_mode();
    test_random();

    drain();
    repeat (4) @(posedge clk);
    if (n_fail == 0) begin
      $display("[door_open_monitor_led_status_unit] OK");
    end else begin
      $display("[door_open_monitor_led_status_unit] ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/domls_pkg.sv
rtl/domls_door.sv
rtl/domls_blink.sv
rtl/door_open_monitor_led_status_unit.sv
tb/tb.sv
